>>> src/isotp_pkg.sv
// Shared types and constants for the transport-layer receive session.
`default_nettype none
package isotp_pkg;

   localparam logic [3:0] SF_ID = 4'h0;
   localparam logic [3:0] FF_ID = 4'h1;
   localparam logic [3:0] CF_ID = 4'h2;
   localparam logic [3:0] FC_ID = 4'h3;

   localparam logic [1:0] START_OK   = 2'd0;
   localparam logic [1:0] START_OVFL = 2'd1;

   localparam logic [2:0] CF_PAYLOAD = 3'd7;

   typedef enum logic [1:0] {
      PH_WAIT = 2'd0,
      PH_RECV = 2'd1,
      PH_SUSP = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      FS_CTS  = 2'd0,
      FS_WAIT = 2'd1,
      FS_OVFL = 2'd2
   } flow_status_type;

   typedef enum logic [1:0] {
      IND_NONE = 2'd0,
      IND_OK   = 2'd1,
      IND_FAIL = 2'd2
   } ind_type;

   typedef struct packed {
      logic [15:0] pdu_id;
      logic [47:0] pci_bytes;
      logic [1:0]  start_status;
      logic [15:0] buffer_avail;
      logic        copy_status;
   } req_type;

   typedef struct packed {
      logic            fc_send;
      flow_status_type flow_status;
      logic [7:0]      fc_blocks;
      logic [2:0]      copy_len;
      ind_type         indication;
      logic [15:0]     indication_id;
      phase_type       phase_out;
   } rsp_type;

endpackage
`default_nettype wire

>>> src/isotp_receive_session.sv
// Top level of the transport-layer receive session.
//
//  channel | ports                          | carries
//  --------+--------------------------------+-----------------------------------
//  req     | req_valid, req_stall, req_data | received frame PCI, id, upper answers
//  rsp     | rsp_valid, rsp_stall, rsp_data | flow control, copy length, end report
//
//  One beat per cycle while the result side is not stalled; each frame passes
//  the two register stages: the input register, then the result register.
//  Session state updates as the frame moves from the input to the result register.
//  Reset is synchronous and clears both stage valids and the session state.
//  A stalled result holds; the input register still takes one further beat.
`default_nettype none
module isotp_receive_session (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire isotp_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output isotp_pkg::rsp_type     rsp_data
);
   import isotp_pkg::*;

   logic    in_valid, out_free, fire;
   req_type in_data;
   rsp_type result;

   assign fire = in_valid && out_free;

   isotp_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .fire      (fire),
      .in_valid  (in_valid),
      .in_data   (in_data)
   );

   isotp_session u_session (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .in_data (in_data),
      .result  (result)
   );

   isotp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while result side is free");

   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("processed beat produced no result");

   a_held_result_blocks_fire: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !fire)
      else $error("result overwritten while stalled");

endmodule
`default_nettype wire

>>> src/isotp_in_stage.sv
// Input register: holds one received frame beat until the session logic takes it.
`default_nettype none
module isotp_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire isotp_pkg::req_type req_data,
   input  wire logic              fire,
   output logic                   in_valid,
   output isotp_pkg::req_type     in_data
);
   import isotp_pkg::*;

   logic    valid_ff, valid_in;
   req_type data_ff;
   logic    load;

   assign req_stall = valid_ff && !fire;
   assign load      = req_valid && !req_stall;
   assign valid_in  = load || (valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_data;
      end
   end

   assign in_valid = valid_ff;
   assign in_data  = data_ff;

endmodule
`default_nettype wire

>>> src/isotp_session.sv
// Session state and single-pass frame handling: decode, sequence check, block count.
`default_nettype none
module isotp_session (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire isotp_pkg::req_type in_data,
   output isotp_pkg::rsp_type     result
);
   import isotp_pkg::*;

   localparam logic [16:0] RECIP_7 = 17'd74899;

   phase_type   phase_ff, phase_in;
   logic [15:0] session_ff, session_in;
   logic [15:0] total_ff, total_in;
   logic [15:0] recv_ff, recv_in;
   logic [3:0]  seq_ff, seq_in;
   logic [7:0]  but_ff, but_in;

   logic [3:0]  pci_kind, nib;
   logic        is_sf, is_ff, is_cf;
   logic [11:0] ff_len12;
   logic        ff_escape, too_big;
   logic [15:0] ff_len;
   logic [15:0] rem_cur, recv_new, rem_sel;
   logic [2:0]  cf_copy;
   logic [16:0] bc_arg;
   logic [33:0] bc_prod;
   logic [14:0] blocks;
   logic        blocks_nz;
   logic [7:0]  blocks_sat, but_dec;
   logic        in_recv, sf_take, sf_fit, ff_open, ff_ovfl;
   logic        cf_hit, seq_ok, cf_good, cf_fail, cf_done, cf_more, cf_cts, cf_wait;

   assign pci_kind = in_data.pci_bytes[47:44];
   assign nib      = in_data.pci_bytes[43:40];

   always_comb begin
      is_sf = 1'b0;
      is_ff = 1'b0;
      is_cf = 1'b0;
      unique case (pci_kind)
         SF_ID:   is_sf = 1'b1;
         FF_ID:   is_ff = 1'b1;
         CF_ID:   is_cf = 1'b1;
         FC_ID:   ;
         default: ;
      endcase
   end

   assign ff_len12  = {nib, in_data.pci_bytes[39:32]};
   assign ff_escape = (ff_len12 == 12'd0);
   assign too_big   = ff_escape && (in_data.pci_bytes[31:16] != 16'd0);
   assign ff_len    = ff_escape ? in_data.pci_bytes[15:0] : {4'd0, ff_len12};

   assign rem_cur  = total_ff - recv_ff;
   assign cf_copy  = (rem_cur < {13'd0, CF_PAYLOAD}) ? rem_cur[2:0] : CF_PAYLOAD;
   assign recv_new = recv_ff + {13'd0, cf_copy};
   assign rem_sel  = (phase_ff == PH_RECV) ? (total_ff - recv_new) : ff_len;

   // ceil(rem / 7) when the buffer holds the rest, else floor(avail / 7)
   assign bc_arg     = ({1'b0, in_data.buffer_avail} >= {1'b0, rem_sel})
                       ? ({1'b0, rem_sel} + 17'd6) : {1'b0, in_data.buffer_avail};
   assign bc_prod    = {17'd0, bc_arg} * {17'd0, RECIP_7};
   assign blocks     = bc_prod[33:19];
   assign blocks_nz  = (blocks != 15'd0);
   assign blocks_sat = (blocks[14:8] != 7'd0) ? 8'hFF : blocks[7:0];
   assign but_dec    = (but_ff != 8'd0) ? (but_ff - 8'd1) : 8'd0;

   assign in_recv = (phase_ff == PH_RECV);
   assign sf_take = !in_recv && is_sf && (nib != 4'd0) && !nib[3]
                    && (in_data.start_status == START_OK);
   assign sf_fit  = ({12'd0, nib} <= in_data.buffer_avail);
   assign ff_open = !in_recv && is_ff && (in_data.start_status == START_OK) && !too_big;
   assign ff_ovfl = !in_recv && is_ff && ((in_data.start_status == START_OVFL)
                    || ((in_data.start_status == START_OK) && too_big));
   assign cf_hit  = in_recv && is_cf && (in_data.pdu_id == session_ff);
   assign seq_ok  = (nib == seq_ff);
   assign cf_good = cf_hit && seq_ok && !in_data.copy_status;
   assign cf_fail = cf_hit && (!seq_ok || in_data.copy_status);
   assign cf_done = cf_good && (recv_new == total_ff);
   assign cf_more = cf_good && !cf_done;
   assign cf_cts  = cf_more && blocks_nz && (but_dec == 8'd0);
   assign cf_wait = cf_more && !blocks_nz;

   // next state
   always_comb begin
      phase_in   = phase_ff;
      session_in = session_ff;
      total_in   = total_ff;
      recv_in    = recv_ff;
      seq_in     = seq_ff;
      but_in     = but_ff;
      priority if (sf_take || ff_ovfl || cf_fail || cf_done) begin
         phase_in = PH_WAIT;
         total_in = 16'd0;
         recv_in  = 16'd0;
         seq_in   = 4'd0;
         but_in   = 8'd0;
      end else if (ff_open) begin
         session_in = in_data.pdu_id;
         total_in   = ff_len;
         recv_in    = 16'd0;
         seq_in     = 4'd1;
         phase_in   = blocks_nz ? PH_RECV : PH_SUSP;
         but_in     = blocks_nz ? blocks_sat : 8'd0;
      end else if (cf_more) begin
         recv_in  = recv_new;
         seq_in   = seq_ff + 4'd1;
         phase_in = blocks_nz ? PH_RECV : PH_SUSP;
         but_in   = cf_cts ? blocks_sat : but_dec;
      end else begin
      end
   end

   // result beat
   always_comb begin
      result               = '0;
      result.flow_status   = FS_CTS;
      result.indication    = IND_NONE;
      result.phase_out     = phase_in;
      if (sf_take) begin
         result.copy_len      = sf_fit ? nib[2:0] : 3'd0;
         result.indication    = (sf_fit && !in_data.copy_status) ? IND_OK : IND_FAIL;
         result.indication_id = in_data.pdu_id;
      end
      if (ff_open) begin
         result.fc_send     = 1'b1;
         result.flow_status = blocks_nz ? FS_CTS : FS_WAIT;
         result.fc_blocks   = blocks_nz ? blocks_sat : 8'd0;
      end
      if (ff_ovfl) begin
         result.fc_send     = 1'b1;
         result.flow_status = FS_OVFL;
      end
      if (cf_hit && seq_ok) begin
         result.copy_len = cf_copy;
      end
      if (cf_fail || cf_done) begin
         result.indication    = cf_done ? IND_OK : IND_FAIL;
         result.indication_id = session_ff;
      end
      if (cf_cts) begin
         result.fc_send   = 1'b1;
         result.fc_blocks = blocks_sat;
      end
      if (cf_wait) begin
         result.fc_send     = 1'b1;
         result.flow_status = FS_WAIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_WAIT;
         session_ff <= 16'd0;
         total_ff   <= 16'd0;
         recv_ff    <= 16'd0;
         seq_ff     <= 4'd0;
         but_ff     <= 8'd0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         session_ff <= session_in;
         total_ff   <= total_in;
         recv_ff    <= recv_in;
         seq_ff     <= seq_in;
         but_ff     <= but_in;
      end
   end

   a_recv_has_credit: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_RECV) |-> (but_ff != 8'd0))
      else $error("receiving with no block credit");

   a_recv_not_full: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_RECV) |-> (recv_ff < total_ff))
      else $error("receiving after all bytes counted");

   a_wait_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_WAIT) |-> (total_ff == 16'd0 && recv_ff == 16'd0 && but_ff == 8'd0))
      else $error("idle session holds stale counters");

endmodule
`default_nettype wire

>>> src/isotp_out_stage.sv
// Result register: holds one result beat until the receiver takes it.
`default_nettype none
module isotp_out_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire isotp_pkg::rsp_type result,
   output logic                   out_free,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output isotp_pkg::rsp_type     rsp_data
);
   import isotp_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign out_free = !valid_ff || !rsp_stall;
   assign valid_in = fire || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
`default_nettype wire

>>> dv/isotp_receive_session_tb.sv
// Self-checking testbench for the transport-layer receive session.
module isotp_receive_session_tb;
   import isotp_pkg::*;

   localparam logic [1:0] START_REFUSED = 2'd2;
   localparam logic [1:0] START_SPARE   = 2'd3;
   localparam logic [3:0] RSVD_ID       = 4'hF;
   localparam int unsigned RANDOM_ITEMS = 1950;
   localparam int unsigned SQUEEZE_CYCLES = 80;

   typedef struct {
      req_type frame;
      bit      pinned;
      rsp_type want;
   } script_row;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // session state as the predictor sees it
   phase_type   sess_phase = PH_WAIT;
   logic [15:0] sess_id = '0;
   logic [15:0] sess_total = '0;
   logic [15:0] sess_rcvd = '0;
   logic [3:0]  sess_seq = '0;
   logic [7:0]  sess_credit = '0;

   rsp_type     expected_rsp[$];
   script_row   script[$];
   bit          pin_on = 1'b0;
   rsp_type     pin_rsp = '0;
   bit          quiet = 1'b0;
   bit          squeeze = 1'b0;
   int unsigned mismatches = 0;
   int unsigned n_checked = 0;
   int unsigned n_fc = 0;
   int unsigned n_done = 0;
   int unsigned n_failed = 0;

   isotp_receive_session u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("timeout with %0d results outstanding", expected_rsp.size());
      $display("FAILURE");
      $finish;
   end

   function automatic void close_session();
      sess_phase  = PH_WAIT;
      sess_total  = '0;
      sess_rcvd   = '0;
      sess_seq    = '0;
      sess_credit = '0;
   endfunction

   function automatic int unsigned credit_for(logic [15:0] avail);
      int unsigned left;
      left = 16'(sess_total - sess_rcvd);
      if (avail >= left) return (left + CF_PAYLOAD - 1) / CF_PAYLOAD;
      return avail / CF_PAYLOAD;
   endfunction

   function automatic logic [7:0] sat_blocks(int unsigned blocks);
      return (blocks > 255) ? 8'd255 : 8'(blocks);
   endfunction

   function automatic rsp_type predict_frame(req_type f);
      rsp_type     r;
      logic [7:0]  b0;
      logic [31:0] len;
      logic [15:0] left;
      int unsigned blocks;
      bit          too_big;
      r = '0;
      b0 = f.pci_bytes[47:40];
      if (sess_phase != PH_RECV) begin
         if (b0[7:4] == SF_ID) begin
            if (b0[3:0] >= 1 && b0[3:0] <= 7 && f.start_status == START_OK) begin
               if (f.buffer_avail >= b0[3:0]) begin
                  r.copy_len = b0[2:0];
                  r.indication = f.copy_status ? IND_FAIL : IND_OK;
               end else begin
                  r.indication = IND_FAIL;
               end
               r.indication_id = f.pdu_id;
               close_session();
            end
         end else if (b0[7:4] == FF_ID) begin
            len = {20'd0, b0[3:0], f.pci_bytes[39:32]};
            too_big = 1'b0;
            if (len == 0) begin
               len = f.pci_bytes[31:0];
               too_big = len > 32'hFFFF;
            end
            if (f.start_status == START_OK && !too_big) begin
               close_session();
               sess_id = f.pdu_id;
               sess_total = len[15:0];
               sess_seq = 4'd1;
               blocks = credit_for(f.buffer_avail);
               r.fc_send = 1'b1;
               if (blocks > 0) begin
                  r.flow_status = FS_CTS;
                  r.fc_blocks = sat_blocks(blocks);
                  sess_credit = r.fc_blocks;
                  sess_phase = PH_RECV;
               end else begin
                  r.flow_status = FS_WAIT;
                  sess_phase = PH_SUSP;
               end
            end else if (f.start_status == START_OVFL || f.start_status == START_OK) begin
               r.fc_send = 1'b1;
               r.flow_status = FS_OVFL;
               close_session();
            end
         end
      end else if (b0[7:4] == CF_ID && f.pdu_id == sess_id) begin
         if (b0[3:0] == sess_seq && !f.copy_status) begin
            left = sess_total - sess_rcvd;
            r.copy_len = (left < CF_PAYLOAD) ? left[2:0] : CF_PAYLOAD;
            sess_rcvd = sess_rcvd + r.copy_len;
            if (sess_credit > 0) sess_credit = sess_credit - 1;
            if (sess_rcvd == sess_total) begin
               r.indication = IND_OK;
               r.indication_id = sess_id;
               close_session();
            end else begin
               sess_seq = sess_seq + 4'd1;
               blocks = credit_for(f.buffer_avail);
               if (blocks > 0) begin
                  if (sess_credit == 0) begin
                     r.fc_send = 1'b1;
                     r.flow_status = FS_CTS;
                     r.fc_blocks = sat_blocks(blocks);
                     sess_credit = r.fc_blocks;
                  end
               end else begin
                  r.fc_send = 1'b1;
                  r.flow_status = FS_WAIT;
                  sess_phase = PH_SUSP;
               end
            end
         end else begin
            // copy refused still reports the bytes offered
            if (b0[3:0] == sess_seq) begin
               left = sess_total - sess_rcvd;
               r.copy_len = (left < CF_PAYLOAD) ? left[2:0] : CF_PAYLOAD;
            end
            r.indication = IND_FAIL;
            r.indication_id = sess_id;
            close_session();
         end
      end
      r.phase_out = sess_phase;
      return r;
   endfunction

   task automatic report_mismatch(string what);
      mismatches++;
      $display("mismatch at result %0d: %s", n_checked, what);
   endtask

   task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   always @(posedge clock) begin : scoreboard
      rsp_type want;
      rsp_type pred;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("result with nothing expected");
            end else begin
               want = expected_rsp.pop_front();
               check_field("fc_send", rsp_data.fc_send, want.fc_send);
               check_field("flow_status", rsp_data.flow_status, want.flow_status);
               check_field("fc_blocks", rsp_data.fc_blocks, want.fc_blocks);
               check_field("copy_len", rsp_data.copy_len, want.copy_len);
               check_field("indication", rsp_data.indication, want.indication);
               check_field("indication_id", rsp_data.indication_id, want.indication_id);
               check_field("phase_out", rsp_data.phase_out, want.phase_out);
               if (want.fc_send) n_fc++;
               if (want.indication == IND_OK) n_done++;
               if (want.indication == IND_FAIL) n_failed++;
            end
            n_checked++;
         end
         if (req_valid && !req_stall) begin
            pred = predict_frame(req_data);
            expected_rsp.push_back(pin_on ? pin_rsp : pred);
         end
      end
   end

   function automatic int unsigned gap_len();
      int unsigned r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 9);
      return $urandom_range(10, 30);
   endfunction

   function automatic req_type frame(logic [15:0] id, logic [47:0] pci, logic [1:0] start,
                                     logic [15:0] avail, logic copy);
      req_type f;
      f.pdu_id = id;
      f.pci_bytes = pci;
      f.start_status = start;
      f.buffer_avail = avail;
      f.copy_status = copy;
      return f;
   endfunction

   function automatic rsp_type outcome(logic fc, flow_status_type st, logic [7:0] blk,
                                       logic [2:0] cl, ind_type ind, logic [15:0] iid,
                                       phase_type ph);
      rsp_type r;
      r.fc_send = fc;
      r.flow_status = st;
      r.fc_blocks = blk;
      r.copy_len = cl;
      r.indication = ind;
      r.indication_id = iid;
      r.phase_out = ph;
      return r;
   endfunction

   function automatic logic [39:0] rand40();
      return {8'($urandom), 32'($urandom)};
   endfunction

   function automatic logic [15:0] rand_avail(int unsigned big_pct);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < big_pct) return 16'hFFFF;
      if (r < big_pct + (100 - big_pct) / 2) return 16'($urandom);
      return 16'($urandom_range(0, 40));
   endfunction

   function automatic req_type first_frame();
      req_type     f;
      logic [31:0] len;
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 60);
      else if (r < 90) len = $urandom_range(61, 300);
      else if (r < 95) len = $urandom_range(301, 4095);
      else if (r < 98) len = $urandom_range(0, 65535);
      else len = $urandom;
      f.pdu_id = 16'($urandom);
      if (len > 32'hFFF || len == 0 || $urandom_range(0, 9) == 0)
         f.pci_bytes = {FF_ID, 12'h000, len};
      else
         f.pci_bytes = {FF_ID, len[11:0], 32'($urandom)};
      f.start_status = ($urandom_range(0, 99) < 88) ? START_OK : 2'($urandom_range(1, 3));
      f.buffer_avail = rand_avail(50);
      f.copy_status = 1'($urandom);
      return f;
   endfunction

   function automatic req_type next_cf();
      req_type    f;
      logic [3:0] seq;
      f.pdu_id = ($urandom_range(0, 29) == 0) ? 16'($urandom) : sess_id;
      seq = ($urandom_range(0, 24) == 0) ? 4'($urandom) : sess_seq;
      f.pci_bytes = {CF_ID, seq, rand40()};
      f.start_status = 2'($urandom);
      f.buffer_avail = rand_avail(70);
      f.copy_status = ($urandom_range(0, 39) == 0);
      return f;
   endfunction

   function automatic req_type noise_frame();
      req_type     f;
      int unsigned r;
      f.pdu_id = ($urandom_range(0, 3) == 0) ? sess_id : 16'($urandom);
      f.start_status = 2'($urandom);
      f.buffer_avail = rand_avail(30);
      f.copy_status = 1'($urandom);
      r = $urandom_range(0, 99);
      if (r < 40) begin
         f.pci_bytes = {SF_ID, 4'($urandom), rand40()};
         if ($urandom_range(0, 9) < 7) f.start_status = START_OK;
      end else if (r < 55) begin
         f.pci_bytes = {CF_ID, 4'($urandom), rand40()};
      end else begin
         f.pci_bytes = {16'($urandom), 32'($urandom)};
      end
      return f;
   endfunction

   // called at a falling edge; returns at a falling edge after the beat and its gap
   task automatic send_frame(req_type f, bit pinned, rsp_type want);
      int unsigned idle;
      req_valid = 1'b1;
      req_data = f;
      pin_on = pinned;
      pin_rsp = want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
      idle = gap_len();
      repeat (idle) @(negedge clock);
   endtask

   initial begin : receiver
      int unsigned n;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (squeeze) begin
            rsp_stall = 1'b1;
            for (n = 0; n < SQUEEZE_CYCLES; n++) @(negedge clock);
            squeeze = 1'b0;
         end
         rsp_stall = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         n = gap_len();
         if (n > 0) begin
            rsp_stall = 1'b1;
            repeat (n) @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      int unsigned sent;
      int unsigned cfs;
      bit          squeezed;
      script.push_back('{frame(16'h1234, {SF_ID, 4'd3, 40'h0}, START_OK, 16'hFFFF, 1'b0), 1'b1,
                         outcome(1'b0, FS_CTS, 8'd0, 3'd3, IND_OK, 16'h1234, PH_WAIT)});
      script.push_back('{frame(16'h0000, {SF_ID, 4'd7, 40'hFF_FFFF_FFFF}, START_OK, 16'd6, 1'b0),
                         1'b1, outcome(1'b0, FS_CTS, 8'd0, 3'd0, IND_FAIL, 16'h0000, PH_WAIT)});
      script.push_back('{frame(16'hFFFF, {SF_ID, 4'd0, 40'h0}, START_OK, 16'hFFFF, 1'b0), 1'b1,
                         outcome(1'b0, FS_CTS, 8'd0, 3'd0, IND_NONE, 16'h0, PH_WAIT)});
      script.push_back('{frame(16'hFFFF, {SF_ID, 4'hF, 40'hFF_FFFF_FFFF}, START_OK, 16'hFFFF, 1'b1),
                         1'b1, outcome(1'b0, FS_CTS, 8'd0, 3'd0, IND_NONE, 16'h0, PH_WAIT)});
      script.push_back('{frame(16'h0042, {SF_ID, 4'd4, 40'h0}, START_REFUSED, 16'hFFFF, 1'b0), 1'b1,
                         outcome(1'b0, FS_CTS, 8'd0, 3'd0, IND_NONE, 16'h0, PH_WAIT)});
      script.push_back('{frame(16'h0042, {SF_ID, 4'd4, 40'h0}, START_SPARE, 16'hFFFF, 1'b0), 1'b1,
                         outcome(1'b0, FS_CTS, 8'd0, 3'd0, IND_NONE, 16'h0, PH_WAIT)});
      script.push_back('{frame(16'h0077, {SF_ID, 4'd5, 40'h0}, START_OK, 16'd5, 1'b1), 1'b1,
                         outcome(1'b0, FS_CTS, 8'd0, 3'd5, IND_FAIL, 16'h0077, PH_WAIT)});
      script.push_back('{frame(16'h0001, {FC_ID, 44'h0}, START_OK, 16'hFFFF, 1'b0), 1'b1,
                         outcome(1'b0, FS_CTS, 8'd0, 3'd0, IND_NONE, 16'h0, PH_WAIT)});
      script.push_back('{frame(16'h0001, {RSVD_ID, 44'hFFF_FFFF_FFFF}, START_OK, 16'h0, 1'b0),
                         1'b1, outcome(1'b0, FS_CTS, 8'd0, 3'd0, IND_NONE, 16'h0, PH_WAIT)});
      script.push_back('{frame(16'h0010, {FF_ID, 12'h0, 32'h0001_0000}, START_OK, 16'hFFFF, 1'b0),
                         1'b1, outcome(1'b1, FS_OVFL, 8'd0, 3'd0, IND_NONE, 16'h0, PH_WAIT)});
      script.push_back('{frame(16'h0010, {FF_ID, 12'h0, 32'h0}, START_OK, 16'hFFFF, 1'b0), 1'b1,
                         outcome(1'b1, FS_WAIT, 8'd0, 3'd0, IND_NONE, 16'h0, PH_SUSP)});
      script.push_back('{frame(16'h0010, {CF_ID, 4'd1, 40'h0}, START_OK, 16'hFFFF, 1'b0), 1'b1,
                         outcome(1'b0, FS_CTS, 8'd0, 3'd0, IND_NONE, 16'h0, PH_SUSP)});
      script.push_back('{frame(16'h0010, {FF_ID, 12'd20, 32'h0}, START_OVFL, 16'hFFFF, 1'b0), 1'b1,
                         outcome(1'b1, FS_OVFL, 8'd0, 3'd0, IND_NONE, 16'h0, PH_WAIT)});
      script.push_back('{frame(16'h0010, {FF_ID, 12'd20, 32'h0}, START_REFUSED, 16'hFFFF, 1'b0),
                         1'b1, outcome(1'b0, FS_CTS, 8'd0, 3'd0, IND_NONE, 16'h0, PH_WAIT)});
      script.push_back('{frame(16'h00AA, {FF_ID, 12'd20, 32'h0}, START_OK, 16'hFFFF, 1'b0), 1'b1,
                         outcome(1'b1, FS_CTS, 8'd3, 3'd0, IND_NONE, 16'h0, PH_RECV)});
      script.push_back('{frame(16'h00AB, {CF_ID, 4'd1, 40'h0}, START_OK, 16'hFFFF, 1'b0), 1'b0, '0});
      script.push_back('{frame(16'h00AA, {CF_ID, 4'd1, 40'h0}, START_OK, 16'hFFFF, 1'b0), 1'b0, '0});
      script.push_back('{frame(16'h00AA, {CF_ID, 4'd2, 40'h0}, START_OK, 16'h0, 1'b0), 1'b0, '0});
      script.push_back('{frame(16'hFFFF, {FF_ID, 12'hFFF, 32'h0}, START_OK, 16'hFFFF, 1'b0), 1'b1,
                         outcome(1'b1, FS_CTS, 8'd255, 3'd0, IND_NONE, 16'h0, PH_RECV)});
      script.push_back('{frame(16'hFFFF, {CF_ID, 4'd2, 40'h0}, START_OK, 16'hFFFF, 1'b0), 1'b1,
                         outcome(1'b0, FS_CTS, 8'd0, 3'd0, IND_FAIL, 16'hFFFF, PH_WAIT)});
      script.push_back('{frame(16'h0005, {FF_ID, 12'd10, 32'h0}, START_OK, 16'd7, 1'b0), 1'b1,
                         outcome(1'b1, FS_CTS, 8'd1, 3'd0, IND_NONE, 16'h0, PH_RECV)});
      script.push_back('{frame(16'h0005, {CF_ID, 4'd1, 40'h0}, START_OK, 16'd3, 1'b0), 1'b0, '0});
      script.push_back('{frame(16'h0005, {CF_ID, 4'd2, 40'h0}, START_OK, 16'd0, 1'b0), 1'b0, '0});
      script.push_back('{frame(16'h0006, {FF_ID, 12'd9, 32'h0}, START_OK, 16'hFFFF, 1'b0), 1'b0, '0});
      script.push_back('{frame(16'h0006, {CF_ID, 4'd1, 40'h0}, START_OK, 16'hFFFF, 1'b1), 1'b0, '0});

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (script[i]) send_frame(script[i].frame, script[i].pinned, script[i].want);

      sent = 0;
      squeezed = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 39) == 0) quiet = !quiet;
         if (!squeezed && sent >= 400) begin
            squeeze = 1'b1;
            squeezed = 1'b1;
         end
         if ($urandom_range(0, 99) < 75) begin
            send_frame(first_frame(), 1'b0, '0);
            sent++;
            cfs = $urandom_range(1, 40);
            while (sess_phase == PH_RECV && cfs > 0) begin
               send_frame(next_cf(), 1'b0, '0);
               sent++;
               cfs--;
            end
         end else begin
            send_frame(noise_frame(), 1'b0, '0);
            sent++;
         end
      end

      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("%0d results checked: %0d flow control frames, %0d transfers done, %0d failed",
               n_checked, n_fc, n_done, n_failed);
      $display("%0d mismatches, including a long result hold-off with the input backed up",
               mismatches);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
